FILE: rtl/dss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg: shared types and constants for dominant_screen_select
// Sizes of the screen table, coordinate widths, action and register codes,
// and the structs that travel between the pipeline stages.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int MAX_SCREENS = 8;
  localparam int COORD_BITS  = 16;
  localparam int SIZE_BITS   = COORD_BITS - 1;
  localparam int CNT_W       = 4;
  localparam int OUT_IDX_W   = 3;
  localparam int IDX_W       = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;
  localparam int LANES       = 1 << IDX_W;
  localparam int LVL         = IDX_W;
  // Two extra bits hold a coordinate plus a size and the difference of two such sums.
  localparam int EXT_W       = COORD_BITS + 2;
  localparam int AREA_W      = 2 * SIZE_BITS;

  typedef logic signed [EXT_W-1:0]  ext_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [SIZE_BITS-1:0]     size_t;
  typedef logic [AREA_W-1:0]        area_t;
  typedef logic [OUT_IDX_W-1:0]     sidx_t;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_POINT = 2'd1,
    ACT_RECT  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_SCREEN_COUNT = 2'd0,
    REG_ROOT_WIDTH   = 2'd1,
    REG_ROOT_HEIGHT  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0] screen_count;
    size_t            root_width;
    size_t            root_height;
  } dss_cfg_t;

  // Query beat marker: valid and whether it is a rectangle query.
  typedef struct packed {
    logic vld;
    logic rect;
  } dss_side_t;

  typedef struct packed {
    idx_t  idx;
    ext_t  x0;
    ext_t  y0;
    ext_t  x1;
    ext_t  y1;
    ext_t  px;
    ext_t  py;
    size_t w;
    size_t h;
  } dss_s1_t;

endpackage

FILE: rtl/dominant_screen_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dominant_screen_select: screen table with point and rectangle queries
// Loads fill a table of screen rectangles; point queries return the first
// screen above 0 holding the clamped point, else screen 0; rectangle queries
// the screen of largest overlap, falling back to a midpoint lookup if none overlaps.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                                          Handshake
//  -------  ---------------------------------------------  --------------------------
//  input    in_action, in_entry_index, in_pos_x/y,         start high, busy low
//           in_rect_width, in_rect_height
//  result   out_screen_index, out_overlap_area,            out_strobe, one cycle
//           out_used_fallback
//  config   cfg_we, cfg_index, cfg_data                    cfg_we high
//
//  A beat is taken every cycle; busy stays low. A query's result reaches the
//  output ports through the input stage, lane compare, area multiply, a
//  register for each level of the best-area tree, and the result register.
//  Loads give no result. Reset clears the pipeline valids and loads the
//  register defaults; table entries hold nothing meaningful until loaded.
//  The receiver cannot stall.
// ----------------------------------------------------------------------------
module dominant_screen_select (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_action,
  input  logic [2:0]                     in_entry_index,
  input  logic [dss_pkg::COORD_BITS-1:0] in_pos_x,
  input  logic [dss_pkg::COORD_BITS-1:0] in_pos_y,
  input  dss_pkg::size_t                 in_rect_width,
  input  dss_pkg::size_t                 in_rect_height,
  output logic                           out_strobe,
  output dss_pkg::sidx_t                 out_screen_index,
  output dss_pkg::area_t                 out_overlap_area,
  output logic                           out_used_fallback,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  dss_pkg::size_t                 cfg_data
);

  dss_pkg::dss_cfg_t  cfg_r, cfg_nxt;
  dss_pkg::dss_side_t s1_side, s2_side;
  logic               s1_load;
  dss_pkg::dss_s1_t   s1_data;
  dss_pkg::size_t     s2_iw [dss_pkg::LANES];
  dss_pkg::size_t     s2_ih [dss_pkg::LANES];
  logic [dss_pkg::LANES-1:0] s2_cont;
  logic               accept;

  // Every stage advances each cycle, so there is never a reason to hold off.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (dss_pkg::cfg_reg_t'(cfg_index))
        dss_pkg::REG_SCREEN_COUNT: cfg_nxt.screen_count = cfg_data[dss_pkg::CNT_W-1:0];
        dss_pkg::REG_ROOT_WIDTH:   cfg_nxt.root_width   = cfg_data;
        dss_pkg::REG_ROOT_HEIGHT:  cfg_nxt.root_height  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_count <= dss_pkg::CNT_W'(1);
      cfg_r.root_width   <= dss_pkg::size_t'(1024);
      cfg_r.root_height  <= dss_pkg::size_t'(768);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dss_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .cfg            (cfg_r),
    .in_action      (in_action),
    .in_entry_index (in_entry_index),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .s1_side        (s1_side),
    .s1_load        (s1_load),
    .s1_data        (s1_data)
  );

  dss_lanes u_lanes (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .s1_side (s1_side),
    .s1_load (s1_load),
    .s1_data (s1_data),
    .s2_side (s2_side),
    .s2_iw   (s2_iw),
    .s2_ih   (s2_ih),
    .s2_cont (s2_cont)
  );

  dss_argmax u_argmax (
    .clk               (clk),
    .rst_n             (rst_n),
    .s2_side           (s2_side),
    .s2_iw             (s2_iw),
    .s2_ih             (s2_ih),
    .s2_cont           (s2_cont),
    .out_strobe        (out_strobe),
    .out_screen_index  (out_screen_index),
    .out_overlap_area  (out_overlap_area),
    .out_used_fallback (out_used_fallback)
  );

endmodule

FILE: rtl/dss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_front: input stage
// Registers an accepted beat, forms the rectangle edges and the clamped
// lookup point (the point itself or the rectangle midpoint).
// ----------------------------------------------------------------------------
module dss_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  dss_pkg::dss_cfg_t              cfg,
  input  logic [1:0]                     in_action,
  input  logic [2:0]                     in_entry_index,
  input  logic [dss_pkg::COORD_BITS-1:0] in_pos_x,
  input  logic [dss_pkg::COORD_BITS-1:0] in_pos_y,
  input  dss_pkg::size_t                 in_rect_width,
  input  dss_pkg::size_t                 in_rect_height,
  output dss_pkg::dss_side_t             s1_side,
  output logic                           s1_load,
  output dss_pkg::dss_s1_t               s1_data
);

  function automatic dss_pkg::ext_t clamp(input dss_pkg::ext_t v, input dss_pkg::size_t bound);
    dss_pkg::ext_t lim;
    dss_pkg::ext_t t;
    lim = dss_pkg::ext_t'(bound) - dss_pkg::ext_t'(1);
    t   = (v < dss_pkg::ext_t'(0)) ? dss_pkg::ext_t'(0) : v;
    return (t > lim) ? lim : t;
  endfunction

  dss_pkg::dss_side_t s1_side_r, s1_side_nxt;
  logic               s1_load_r, s1_load_nxt;
  dss_pkg::dss_s1_t   s1_data_r, s1_data_nxt;

  dss_pkg::ext_t x_e, y_e, qx, qy;
  logic          is_point, is_rect, is_load;

  always_comb begin
    x_e      = dss_pkg::ext_t'($signed(in_pos_x));
    y_e      = dss_pkg::ext_t'($signed(in_pos_y));
    is_load  = (in_action == dss_pkg::ACT_LOAD);
    is_point = (in_action == dss_pkg::ACT_POINT);
    is_rect  = (in_action == dss_pkg::ACT_RECT);
    // A rectangle query looks up its midpoint if nothing overlaps it.
    qx = is_rect ? x_e + dss_pkg::ext_t'(in_rect_width >> 1) : x_e;
    qy = is_rect ? y_e + dss_pkg::ext_t'(in_rect_height >> 1) : y_e;

    s1_side_nxt.vld  = accept && (is_point || is_rect);
    s1_side_nxt.rect = is_rect;
    s1_load_nxt      = accept && is_load && (int'(in_entry_index) < dss_pkg::MAX_SCREENS);

    s1_data_nxt.idx = dss_pkg::idx_t'(in_entry_index);
    s1_data_nxt.x0  = x_e;
    s1_data_nxt.y0  = y_e;
    s1_data_nxt.x1  = x_e + dss_pkg::ext_t'(in_rect_width);
    s1_data_nxt.y1  = y_e + dss_pkg::ext_t'(in_rect_height);
    s1_data_nxt.px  = clamp(qx, cfg.root_width);
    s1_data_nxt.py  = clamp(qy, cfg.root_height);
    s1_data_nxt.w   = in_rect_width;
    s1_data_nxt.h   = in_rect_height;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r <= '0;
      s1_load_r <= 1'b0;
    end else begin
      s1_side_r <= s1_side_nxt;
      s1_load_r <= s1_load_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_data_r <= s1_data_nxt;
  end

  assign s1_side = s1_side_r;
  assign s1_load = s1_load_r;
  assign s1_data = s1_data_r;

endmodule

FILE: rtl/dss_lanes.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_lanes: screen table and per-screen compare lanes
// Holds the screen rectangles and, for each screen in parallel, forms the
// clipped overlap width and height and the point containment flag.
// ----------------------------------------------------------------------------
module dss_lanes (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dss_pkg::dss_cfg_t              cfg,
  input  dss_pkg::dss_side_t             s1_side,
  input  logic                           s1_load,
  input  dss_pkg::dss_s1_t               s1_data,
  output dss_pkg::dss_side_t             s2_side,
  output dss_pkg::size_t                 s2_iw [dss_pkg::LANES],
  output dss_pkg::size_t                 s2_ih [dss_pkg::LANES],
  output logic [dss_pkg::LANES-1:0]      s2_cont
);

  logic [dss_pkg::COORD_BITS-1:0] tbl_left_r [dss_pkg::LANES];
  logic [dss_pkg::COORD_BITS-1:0] tbl_top_r  [dss_pkg::LANES];
  dss_pkg::size_t                 tbl_wide_r [dss_pkg::LANES];
  dss_pkg::size_t                 tbl_tall_r [dss_pkg::LANES];

  dss_pkg::dss_side_t          s2_side_r;
  dss_pkg::size_t              iw_r [dss_pkg::LANES];
  dss_pkg::size_t              ih_r [dss_pkg::LANES];
  dss_pkg::size_t              iw_nxt [dss_pkg::LANES];
  dss_pkg::size_t              ih_nxt [dss_pkg::LANES];
  logic [dss_pkg::LANES-1:0]   cont_r, cont_nxt;

  // Loads write the table in the same stage in which queries read it, so a
  // query always sees exactly the loads accepted before it.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      tbl_left_r[s1_data.idx] <= s1_data.x0[dss_pkg::COORD_BITS-1:0];
      tbl_top_r[s1_data.idx]  <= s1_data.y0[dss_pkg::COORD_BITS-1:0];
      tbl_wide_r[s1_data.idx] <= s1_data.w;
      tbl_tall_r[s1_data.idx] <= s1_data.h;
    end
  end

  always_comb begin
    dss_pkg::ext_t left, right, top, bottom;
    dss_pkg::ext_t ix, iy, iw, ih;
    logic          en, hit;
    for (int k = 0; k < dss_pkg::LANES; k++) begin
      left   = dss_pkg::ext_t'($signed(tbl_left_r[k]));
      top    = dss_pkg::ext_t'($signed(tbl_top_r[k]));
      right  = left + dss_pkg::ext_t'(tbl_wide_r[k]);
      bottom = top + dss_pkg::ext_t'(tbl_tall_r[k]);
      en     = (k < dss_pkg::MAX_SCREENS) && (k < int'(cfg.screen_count));
      ix     = (s1_data.x0 > left) ? s1_data.x0 : left;
      iy     = (s1_data.y0 > top) ? s1_data.y0 : top;
      iw     = ((s1_data.x1 < right) ? s1_data.x1 : right) - ix;
      ih     = ((s1_data.y1 < bottom) ? s1_data.y1 : bottom) - iy;
      hit    = en && (iw > dss_pkg::ext_t'(0)) && (ih > dss_pkg::ext_t'(0));
      // A positive overlap is never wider than the query, so it fits a size.
      iw_nxt[k] = hit ? iw[dss_pkg::SIZE_BITS-1:0] : '0;
      ih_nxt[k] = hit ? ih[dss_pkg::SIZE_BITS-1:0] : '0;
      // Screen 0 is the default of the point lookup and never tested.
      cont_nxt[k] = en && (k != 0) &&
                    (s1_data.px >= left) && (s1_data.px < right) &&
                    (s1_data.py >= top) && (s1_data.py < bottom);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_side_r <= '0;
    end else begin
      s2_side_r <= s1_side;
    end
  end

  always_ff @(posedge clk) begin
    iw_r   <= iw_nxt;
    ih_r   <= ih_nxt;
    cont_r <= cont_nxt;
  end

  assign s2_side = s2_side_r;
  assign s2_iw   = iw_r;
  assign s2_ih   = ih_r;
  assign s2_cont = cont_r;

endmodule

FILE: rtl/dss_argmax.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_argmax: overlap areas, best-screen tree and result register
// Multiplies each lane's overlap, picks the largest area through a registered
// pairwise tree (lower index wins ties) and forms the result beat.
// ----------------------------------------------------------------------------
module dss_argmax (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dss_pkg::dss_side_t         s2_side,
  input  dss_pkg::size_t             s2_iw [dss_pkg::LANES],
  input  dss_pkg::size_t             s2_ih [dss_pkg::LANES],
  input  logic [dss_pkg::LANES-1:0]  s2_cont,
  output logic                       out_strobe,
  output dss_pkg::sidx_t             out_screen_index,
  output dss_pkg::area_t             out_overlap_area,
  output logic                       out_used_fallback
);

  dss_pkg::area_t     tree_area_r [dss_pkg::LVL+1][dss_pkg::LANES];
  dss_pkg::idx_t      tree_idx_r  [dss_pkg::LVL+1][dss_pkg::LANES];
  dss_pkg::dss_side_t side_r      [dss_pkg::LVL+1];
  dss_pkg::idx_t      pt_r        [dss_pkg::LVL+1];
  dss_pkg::idx_t      pt_nxt;

  logic           strobe_r, strobe_nxt;
  dss_pkg::sidx_t sidx_r, sidx_nxt;
  dss_pkg::area_t area_r, area_nxt;
  logic           fb_r, fb_nxt;

  // First containing screen from index 1 upward; lane 0 never flags.
  always_comb begin
    pt_nxt = '0;
    for (int k = dss_pkg::LANES - 1; k >= 0; k--) begin
      if (s2_cont[k]) begin
        pt_nxt = dss_pkg::idx_t'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < dss_pkg::LANES; k++) begin
      tree_area_r[0][k] <= dss_pkg::area_t'(s2_iw[k]) * dss_pkg::area_t'(s2_ih[k]);
      tree_idx_r[0][k]  <= dss_pkg::idx_t'(k);
    end
    pt_r[0] <= pt_nxt;
    for (int l = 1; l <= dss_pkg::LVL; l++) begin
      for (int n = 0; n < (dss_pkg::LANES >> l); n++) begin
        if (tree_area_r[l-1][2*n+1] > tree_area_r[l-1][2*n]) begin
          tree_area_r[l][n] <= tree_area_r[l-1][2*n+1];
          tree_idx_r[l][n]  <= tree_idx_r[l-1][2*n+1];
        end else begin
          tree_area_r[l][n] <= tree_area_r[l-1][2*n];
          tree_idx_r[l][n]  <= tree_idx_r[l-1][2*n];
        end
      end
      pt_r[l] <= pt_r[l-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l <= dss_pkg::LVL; l++) begin
        side_r[l] <= '0;
      end
    end else begin
      side_r[0] <= s2_side;
      for (int l = 1; l <= dss_pkg::LVL; l++) begin
        side_r[l] <= side_r[l-1];
      end
    end
  end

  // A zero winning area means no screen overlapped the rectangle.
  always_comb begin
    dss_pkg::dss_side_t fin;
    logic               found;
    fin        = side_r[dss_pkg::LVL];
    found      = fin.rect && (tree_area_r[dss_pkg::LVL][0] != '0);
    strobe_nxt = fin.vld;
    sidx_nxt   = found ? dss_pkg::sidx_t'(tree_idx_r[dss_pkg::LVL][0])
                       : dss_pkg::sidx_t'(pt_r[dss_pkg::LVL]);
    area_nxt   = found ? tree_area_r[dss_pkg::LVL][0] : '0;
    fb_nxt     = fin.rect && !found;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sidx_r <= sidx_nxt;
    area_r <= area_nxt;
    fb_r   <= fb_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_screen_index  = sidx_r;
  assign out_overlap_area  = area_r;
  assign out_used_fallback = fb_r;

endmodule

FILE: verif/dss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_checker: result predictor and scoreboard for dominant_screen_select
// Watches the input, result and register ports. It keeps its own copy of the
// screen table and registers, predicts the screen pick of every query beat,
// and compares each result beat with the oldest pending pick.
// ----------------------------------------------------------------------------
module dss_checker
  import dss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  logic [1:0]             in_action,
  input  logic [2:0]             in_entry_index,
  input  logic [COORD_BITS-1:0]  in_pos_x,
  input  logic [COORD_BITS-1:0]  in_pos_y,
  input  size_t                  in_rect_width,
  input  size_t                  in_rect_height,
  input  logic                   out_strobe,
  input  sidx_t                  out_screen_index,
  input  area_t                  out_overlap_area,
  input  logic                   out_used_fallback,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  size_t                  cfg_data,
  output int                     fail_count,
  output int                     picks_pending
);

  typedef struct packed {
    sidx_t screen;
    area_t area;
    logic  fallback;
  } screen_pick_t;

  logic signed [COORD_BITS-1:0] scr_left [MAX_SCREENS];
  logic signed [COORD_BITS-1:0] scr_top  [MAX_SCREENS];
  size_t                        scr_wide [MAX_SCREENS];
  size_t                        scr_tall [MAX_SCREENS];

  logic [CNT_W-1:0] count_q;
  size_t            root_w_q;
  size_t            root_h_q;

  screen_pick_t pick_queue [$];
  int           mismatches = 0;

  function automatic longint min_l(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint max_l(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  // A root size of zero gives a bound of -1, which pins the coordinate there.
  function automatic longint clamp_to_root(longint v, longint bound);
    return min_l(max_l(0, v), bound - 1);
  endfunction

  function automatic int live_screens();
    return (count_q > MAX_SCREENS) ? MAX_SCREENS : int'(count_q);
  endfunction

  // Screen 0 is the default; the scan for a holder starts at screen 1.
  function automatic sidx_t screen_at_point(longint px, longint py);
    longint cx, cy, left, top;
    cx = clamp_to_root(px, longint'(root_w_q));
    cy = clamp_to_root(py, longint'(root_h_q));
    for (int k = 1; k < live_screens(); k++) begin
      left = longint'(scr_left[k]);
      top  = longint'(scr_top[k]);
      if (cx >= left && cx < left + longint'(scr_wide[k]) &&
          cy >= top && cy < top + longint'(scr_tall[k]))
        return sidx_t'(k);
    end
    return '0;
  endfunction

  function automatic screen_pick_t pick_for_rect(longint x, longint y, longint w,
                                                 longint h);
    screen_pick_t pick;
    longint left, top, ix, iy, iw, ih, area, best_area;
    int best;
    best_area = 0;
    best      = 0;
    for (int k = 0; k < live_screens(); k++) begin
      left = longint'(scr_left[k]);
      top  = longint'(scr_top[k]);
      ix = max_l(x, left);
      iy = max_l(y, top);
      iw = min_l(x + w, left + longint'(scr_wide[k])) - ix;
      ih = min_l(y + h, top + longint'(scr_tall[k])) - iy;
      if (iw > 0 && ih > 0) begin
        area = iw * ih;
        // Strictly larger only, so the lower index keeps a tie.
        if (area > best_area) begin
          best_area = area;
          best      = k;
        end
      end
    end
    if (best_area > 0) begin
      pick.screen   = sidx_t'(best);
      pick.area     = area_t'(best_area);
      pick.fallback = 1'b0;
    end else begin
      pick.screen   = screen_at_point(x + w / 2, y + h / 2);
      pick.area     = '0;
      pick.fallback = 1'b1;
    end
    return pick;
  endfunction

  always @(posedge clk) begin
    screen_pick_t want, got, pick;
    longint x, y;
    if (!rst_n) begin
      pick_queue.delete();
      count_q  = 4'd1;
      root_w_q = 15'd1024;
      root_h_q = 15'd768;
    end else begin
      if (out_strobe) begin
        got.screen   = out_screen_index;
        got.area     = out_overlap_area;
        got.fallback = out_used_fallback;
        if (pick_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing pending: screen %0d area %0d fallback %0b",
                     $realtime, got.screen, got.area, got.fallback);
        end else begin
          want = pick_queue.pop_front();
          if (got.screen !== want.screen || got.area !== want.area ||
              got.fallback !== want.fallback) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("%0t: pick mismatch: expected screen %0d area %0d fallback %0b, ",
                     $realtime, want.screen, want.area, want.fallback);
              $display("got screen %0d area %0d fallback %0b",
                       got.screen, got.area, got.fallback);
            end
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_SCREEN_COUNT: count_q  = cfg_data[CNT_W-1:0];
          REG_ROOT_WIDTH:   root_w_q = cfg_data;
          REG_ROOT_HEIGHT:  root_h_q = cfg_data;
          default: ;
        endcase
      end

      if (start && !busy) begin
        x = longint'($signed(in_pos_x));
        y = longint'($signed(in_pos_y));
        case (in_action)
          ACT_LOAD: begin
            scr_left[in_entry_index] = in_pos_x;
            scr_top[in_entry_index]  = in_pos_y;
            scr_wide[in_entry_index] = in_rect_width;
            scr_tall[in_entry_index] = in_rect_height;
          end
          ACT_POINT: begin
            pick.screen   = screen_at_point(x, y);
            pick.area     = '0;
            pick.fallback = 1'b0;
            pick_queue.push_back(pick);
          end
          ACT_RECT: begin
            pick_queue.push_back(pick_for_rect(x, y, longint'(in_rect_width),
                                               longint'(in_rect_height)));
          end
          default: ;
        endcase
      end
    end
    picks_pending <= pick_queue.size();
    fail_count    <= mismatches;
  end

endmodule

FILE: verif/tb_dominant_screen_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dominant_screen_select: stimulus and verdict for dominant_screen_select
// Loads a screen layout, runs directed point and rectangle queries, then
// random phases under varied register settings with random gaps between
// beats. A side checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_dominant_screen_select;
  import dss_pkg::*;

  localparam int         CYCLE_LIMIT     = 200000;
  localparam int         DRAIN_CYCLES    = 10;
  localparam int         PHASES          = 10;
  localparam int         BEATS_PER_PHASE = 153;
  localparam logic [1:0] ACT_IGNORED     = 2'd3;
  localparam logic [1:0] REG_UNUSED      = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [1:0]            in_action;
  logic [2:0]            in_entry_index;
  logic [COORD_BITS-1:0] in_pos_x;
  logic [COORD_BITS-1:0] in_pos_y;
  size_t                 in_rect_width;
  size_t                 in_rect_height;
  logic                  out_strobe;
  sidx_t                 out_screen_index;
  area_t                 out_overlap_area;
  logic                  out_used_fallback;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  size_t                 cfg_data;

  int   fail_count;
  int   picks_pending;
  int   cycles = 0;
  logic steady;

  dominant_screen_select u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_entry_index    (in_entry_index),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_rect_width     (in_rect_width),
    .in_rect_height    (in_rect_height),
    .out_strobe        (out_strobe),
    .out_screen_index  (out_screen_index),
    .out_overlap_area  (out_overlap_area),
    .out_used_fallback (out_used_fallback),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  dss_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_entry_index    (in_entry_index),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_rect_width     (in_rect_width),
    .in_rect_height    (in_rect_height),
    .out_strobe        (out_strobe),
    .out_screen_index  (out_screen_index),
    .out_overlap_area  (out_overlap_area),
    .out_used_fallback (out_used_fallback),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .picks_pending     (picks_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_dominant_screen_select failed");
      $finish;
    end
  end

  // Holds start high across back-to-back beats when the gap is zero.
  task automatic send_beat(input logic [1:0] act, input int idx, input int x,
                           input int y, input int w, input int h);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start          <= 1'b1;
    in_action      <= act;
    in_entry_index <= idx[2:0];
    in_pos_x       <= x[COORD_BITS-1:0];
    in_pos_y       <= y[COORD_BITS-1:0];
    in_rect_width  <= w[SIZE_BITS-1:0];
    in_rect_height <= h[SIZE_BITS-1:0];
    do @(posedge clk); while (busy);
  endtask

  task automatic write_reg(input logic [1:0] idx, input size_t data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Loads give no result beat, so the drain also waits DRAIN_CYCLES after the last pick to let them settle.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (picks_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly geometry near the root area so screens overlap and queries hit;
  // a quarter of the beats use full-range fields.
  task automatic random_beat();
    int         pick, x, y, w, h;
    logic [1:0] act;
    pick = $urandom_range(0, 99);
    if (pick < 15)      act = ACT_LOAD;
    else if (pick < 55) act = ACT_POINT;
    else if (pick < 95) act = ACT_RECT;
    else                act = ACT_IGNORED;
    if ($urandom_range(0, 3) == 0) begin
      x = $urandom;
      y = $urandom;
      w = $urandom;
      h = $urandom;
    end else begin
      x = int'($urandom_range(0, 2600)) - 300;
      y = int'($urandom_range(0, 2000)) - 300;
      w = $urandom_range(0, 1300);
      h = $urandom_range(0, 1000);
      if ($urandom_range(0, 9) == 0) w = 0;
      if ($urandom_range(0, 9) == 0) h = 0;
    end
    send_beat(act, $urandom_range(0, 7), x, y, w, h);
  endtask

  initial begin : stimulus
    size_t cnt, rw, rh;
    rst_n          = 1'b0;
    start          = 1'b0;
    steady         = 1'b0;
    in_action      = '0;
    in_entry_index = '0;
    in_pos_x       = '0;
    in_pos_y       = '0;
    in_rect_width  = '0;
    in_rect_height = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Four quadrant screens, two at the coordinate extremes, one centered
    // over the quadrants and one empty screen.
    send_beat(ACT_LOAD, 0, 0, 0, 1024, 768);
    send_beat(ACT_LOAD, 1, 1024, 0, 1024, 768);
    send_beat(ACT_LOAD, 2, 0, 768, 1024, 768);
    send_beat(ACT_LOAD, 3, 1024, 768, 1024, 768);
    send_beat(ACT_LOAD, 4, -32768, -32768, 32767, 32767);
    send_beat(ACT_LOAD, 5, 32767, 32767, 32767, 32767);
    send_beat(ACT_LOAD, 6, 512, 384, 1024, 768);
    send_beat(ACT_LOAD, 7, 200, 100, 0, 0);
    // Default registers: only screen 0 is live.
    send_beat(ACT_POINT, 0, 500, 400, 0, 0);
    send_beat(ACT_RECT, 0, 900, 700, 300, 200);
    drain();

    write_reg(REG_SCREEN_COUNT, 15'd8);
    write_reg(REG_ROOT_WIDTH, 15'd2048);
    write_reg(REG_ROOT_HEIGHT, 15'd1536);
    write_reg(REG_UNUSED, 15'h7FFF);
    send_beat(ACT_POINT, 0, 1500, 300, 0, 0);
    send_beat(ACT_POINT, 0, -32768, -32768, 32767, 32767);
    send_beat(ACT_POINT, 0, 32767, 32767, 0, 0);
    send_beat(ACT_RECT, 0, 924, 0, 200, 100);
    send_beat(ACT_RECT, 0, 512, 384, 1024, 768);
    send_beat(ACT_RECT, 0, -32768, -32768, 32767, 32767);
    send_beat(ACT_RECT, 0, 32767, 32767, 32767, 32767);
    send_beat(ACT_RECT, 0, 100, 100, 0, 50);
    send_beat(ACT_RECT, 0, -32768, 30000, 100, 100);
    send_beat(ACT_RECT, 0, 1014, 768, 10, 10);
    send_beat(ACT_IGNORED, 7, -1, -1, 32767, 32767);
    send_beat(ACT_POINT, 0, 600, 500, 0, 0);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin cnt = 15'd8; rw = 15'd2048; rh = 15'd1536; end
        1: begin
          cnt = size_t'($urandom) & 15'h7FF0;
          rw  = 15'd1024;
          rh  = 15'd768;
        end
        2: begin cnt = 15'h7FFF; rw = 15'h7FFF; rh = 15'h7FFF; end
        3: begin cnt = 15'd1; rw = 15'd1; rh = 15'd1; end
        4: begin
          cnt = (size_t'($urandom) & 15'h7FF0) | size_t'($urandom_range(9, 15));
          rw  = '0;
          rh  = '0;
        end
        5: begin
          cnt = size_t'($urandom_range(2, 7));
          rw  = size_t'($urandom_range(1, 32767));
          rh  = size_t'($urandom_range(1, 32767));
        end
        6: begin cnt = 15'd8; rw = '0; rh = 15'd1200; end
        default: begin
          cnt = size_t'($urandom);
          rw  = size_t'($urandom_range(600, 3000));
          rh  = size_t'($urandom_range(400, 2200));
        end
      endcase
      write_reg(REG_SCREEN_COUNT, cnt);
      write_reg(REG_ROOT_WIDTH, rw);
      write_reg(REG_ROOT_HEIGHT, rh);
      write_reg(REG_UNUSED, size_t'($urandom));
      for (int i = 0; i < BEATS_PER_PHASE; i++) begin
        if (i % 25 == 0) steady = ($urandom_range(0, 3) == 0);
        random_beat();
      end
      drain();
    end

    if (fail_count == 0 && picks_pending == 0) begin
      $display("tb_dominant_screen_select passed");
    end else begin
      $display("tb_dominant_screen_select failed");
    end
    $finish;
  end

endmodule

FILE: dominant_screen_select.f
rtl/dss_pkg.sv
rtl/dss_front.sv
rtl/dss_lanes.sv
rtl/dss_argmax.sv
rtl/dominant_screen_select.sv
verif/dss_checker.sv
verif/tb_dominant_screen_select.sv
